/* hdl/ffpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants for the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int POOL_UNITS = 4096;
    localparam int AW         = $clog2(POOL_UNITS);   // header store address
    localparam int SIZE_W     = 12;                   // block size field
    localparam int U_W        = 13;                   // pool unit count
    localparam int P_W        = 14;                   // walk offsets, may overshoot
    localparam int ASZ_W      = 19;                   // rounded request
    localparam int REQ_W      = 20;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_RESIZE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_ZERO     = 3'd1;
    localparam logic [2:0] STAT_RANGE    = 3'd2;
    localparam logic [2:0] STAT_NO_SPACE = 3'd3;
    localparam logic [2:0] STAT_DBL_FREE = 3'd4;
    localparam logic [2:0] STAT_BAD_HDR  = 3'd5;

    localparam logic [1:0] CFG_ALIGN_SHIFT  = 2'd0;
    localparam logic [1:0] CFG_HEADER_UNITS = 2'd1;
    localparam logic [1:0] CFG_POOL_UNITS   = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [REQ_W-1:0] request_bytes;
        logic [AW-1:0]    block_addr;
    } t_in_item;

    typedef struct packed {
        logic              ok;
        logic [2:0]        status;
        logic [AW-1:0]     data_addr;
        logic [SIZE_W-1:0] granted_units;
    } t_out_item;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } t_hdr;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_WHDR,
        S_WNX,
        S_WFAIL,
        S_FHDR,
        S_FNX,
        S_RNX,
        S_WR2,
        S_DONE
    } t_state;

endpackage

/* hdl/first_fit_pool_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_core
// First-fit allocator over a pool of alignment units kept as a chain of
// block headers in one synchronous RAM; a predicted free block is tried first.
// ----------------------------------------------------------------------------
// Throughput: one transfer at a time; the next input is taken once the result
//   sits in the output register.
// Reset: synchronous, active low; the cycle after reset writes the initial
//   free block to entry 0, then the block accepts input. A config write to
//   any of the three registers re-initializes the pool the same way.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ffpa_pkg::t_in_item  i_in_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ffpa_pkg::t_out_item o_out_data,
    // configuration
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data
);

    localparam int AW     = ffpa_pkg::AW;
    localparam int SW     = ffpa_pkg::SIZE_W;
    localparam int UW     = ffpa_pkg::U_W;
    localparam int PW     = ffpa_pkg::P_W;
    localparam int ASW    = ffpa_pkg::ASZ_W;
    localparam int REQW   = ffpa_pkg::REQ_W;

    // ---------------- configuration registers ----------------
    logic [2:0]  r_align_shift;
    logic [4:0]  r_header_units;
    logic [12:0] r_pool_units;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align_shift  <= 3'd3;
            r_header_units <= 5'd1;
            r_pool_units   <= 13'(ffpa_pkg::POOL_UNITS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ffpa_pkg::CFG_ALIGN_SHIFT:  r_align_shift  <= i_cfg_data[2:0];
                ffpa_pkg::CFG_HEADER_UNITS: r_header_units <= i_cfg_data[4:0];
                ffpa_pkg::CFG_POOL_UNITS:   r_pool_units   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturated working values
    logic [2:0]    eff_sh;
    logic [4:0]    eff_hu;
    logic [UW-1:0] eff_u;
    logic [PW-1:0] hu_p, u_p;

    always_comb begin
        eff_sh = (r_align_shift < 3'd2) ? 3'd2 : r_align_shift;
        if (r_header_units < 5'd1)       eff_hu = 5'd1;
        else if (r_header_units > 5'd16) eff_hu = 5'd16;
        else                             eff_hu = r_header_units;
        if (r_pool_units < 13'd16)                          eff_u = 13'd16;
        else if (r_pool_units > 13'(ffpa_pkg::POOL_UNITS))  eff_u = 13'(ffpa_pkg::POOL_UNITS);
        else                                                eff_u = r_pool_units;
        hu_p = PW'(eff_hu);
        u_p  = PW'(eff_u);
    end

    // u - hu always fits the size field
    logic [SW-1:0] u_minus_hu;
    assign u_minus_hu = SW'(eff_u - UW'(eff_hu));

    // ---------------- header RAM ----------------
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    ffpa_pkg::t_hdr    w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [SW:0]       w_rdata;
    ffpa_pkg::t_hdr    q;

    ffpa_ram #(
        .DEPTH (ffpa_pkg::POOL_UNITS),
        .WIDTH (SW + 1)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign q = ffpa_pkg::t_hdr'(w_rdata);

    // ---------------- state ----------------
    ffpa_pkg::t_state    r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [ASW-1:0]      r_asize, n_asize;
    logic [AW-1:0]       r_addr, n_addr;       // data start for free/resize
    logic [AW-1:0]       r_h, n_h;             // header offset for free/resize
    logic [PW-1:0]       r_p, n_p;             // walk position
    logic [PW-1:0]       r_nx, n_nx;           // next header offset
    logic [SW-1:0]       r_bs, n_bs;
    logic [SW-1:0]       r_maxn, n_maxn;
    logic                r_wpv, n_wpv;
    logic [AW-1:0]       r_pp, n_pp;
    logic                r_tries, n_tries;
    logic                r_single, n_single;
    logic                r_pred_valid, n_pred_valid;
    logic [AW-1:0]       r_pred_block, n_pred_block;
    logic [UW-1:0]       r_full_hint, n_full_hint;
    logic [AW-1:0]       r_w2_addr, n_w2_addr;  // deferred second header write
    ffpa_pkg::t_hdr      r_w2_data, n_w2_data;
    ffpa_pkg::t_out_item r_res, n_res;
    ffpa_pkg::t_out_item r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // rounded request of the incoming item
    logic [REQW:0]   req_sum;
    logic [ASW-1:0]  in_asize;
    assign req_sum  = {1'b0, i_in_data.request_bytes} + ((REQW+1)'(1) << eff_sh)
                      - (REQW+1)'(1);
    assign in_asize = ASW'(req_sum >> eff_sh);

    // datapath helpers
    logic [PW-1:0]  p_hu;
    logic [PW-1:0]  w_nx;
    logic [ASW-1:0] bs_a, hu_a;
    logic [PW-1:0]  merged_p;
    logic [PW-1:0]  f_nx;

    always_comb begin
        p_hu     = r_p + hu_p;
        w_nx     = p_hu + PW'(q.size);
        bs_a     = ASW'(q.size);
        hu_a     = ASW'(eff_hu);
        merged_p = PW'(r_bs) + hu_p + PW'(q.size);
        f_nx     = PW'(r_addr) + PW'(q.size);
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_asize      = r_asize;
        n_addr       = r_addr;
        n_h          = r_h;
        n_p          = r_p;
        n_nx         = r_nx;
        n_bs         = r_bs;
        n_maxn       = r_maxn;
        n_wpv        = r_wpv;
        n_pp         = r_pp;
        n_tries      = r_tries;
        n_single     = r_single;
        n_pred_valid = r_pred_valid;
        n_pred_block = r_pred_block;
        n_full_hint  = r_full_hint;
        n_w2_addr    = r_w2_addr;
        n_w2_data    = r_w2_data;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        w_raddr      = '0;

        unique case (r_state)
            ffpa_pkg::S_INIT: begin
                w_we         = 1'b1;
                w_waddr      = '0;
                w_wdata      = '{free: 1'b1, size: u_minus_hu};
                n_pred_valid = 1'b1;
                n_pred_block = '0;
                n_full_hint  = '0;
                n_state      = ffpa_pkg::S_IDLE;
            end

            ffpa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_data.op;
                    n_asize = in_asize;
                    n_addr  = i_in_data.block_addr;
                    n_h     = AW'(i_in_data.block_addr - AW'(eff_hu));
                    n_res   = '0;
                    n_state = ffpa_pkg::S_DONE;
                    unique case (i_in_data.op)
                        ffpa_pkg::OP_CLEAR: begin
                            w_we                = 1'b1;
                            w_waddr             = '0;
                            w_wdata             = '{free: 1'b1, size: u_minus_hu};
                            n_pred_valid        = 1'b1;
                            n_pred_block        = '0;
                            n_full_hint         = '0;
                            n_res.ok            = 1'b1;
                            n_res.data_addr     = AW'(eff_hu);
                            n_res.granted_units = u_minus_hu;
                        end
                        ffpa_pkg::OP_ALLOC: begin
                            if (i_in_data.request_bytes == '0) begin
                                n_res.status = ffpa_pkg::STAT_ZERO;
                            end else if (r_full_hint != '0 &&
                                         in_asize > ASW'(r_full_hint)) begin
                                n_res.status = ffpa_pkg::STAT_NO_SPACE;
                            end else begin
                                // predicted block first, else full walk
                                if (r_pred_valid && UW'(r_pred_block) < eff_u) begin
                                    n_p      = PW'(r_pred_block);
                                    n_single = 1'b1;
                                end else begin
                                    n_p      = '0;
                                    n_single = 1'b0;
                                end
                                n_tries = 1'b1;
                                n_maxn  = SW'(1);
                                n_wpv   = 1'b0;
                                n_pp    = '0;
                                n_state = ffpa_pkg::S_WALK;
                            end
                        end
                        default: begin
                            if (i_in_data.op == ffpa_pkg::OP_RESIZE &&
                                i_in_data.request_bytes == '0) begin
                                n_res.status = ffpa_pkg::STAT_ZERO;
                            end else if (UW'(i_in_data.block_addr) >= eff_u ||
                                         i_in_data.block_addr < AW'(eff_hu)) begin
                                n_res.status = ffpa_pkg::STAT_RANGE;
                            end else begin
                                w_raddr = AW'(i_in_data.block_addr - AW'(eff_hu));
                                n_state = ffpa_pkg::S_FHDR;
                            end
                        end
                    endcase
                end
            end

            ffpa_pkg::S_WALK: begin
                if (p_hu > u_p || (r_single && !r_tries)) begin
                    n_state = ffpa_pkg::S_WFAIL;
                end else begin
                    w_raddr = r_p[AW-1:0];
                    n_state = ffpa_pkg::S_WHDR;
                end
            end

            ffpa_pkg::S_WHDR: begin
                if (UW'(q.size) >= eff_u) begin
                    n_res.status = ffpa_pkg::STAT_BAD_HDR;
                    n_state      = ffpa_pkg::S_DONE;
                end else if (q.free) begin
                    if (q.size > r_maxn) begin
                        n_maxn = q.size;
                        n_wpv  = 1'b1;
                        n_pp   = r_p[AW-1:0];
                    end
                    if (bs_a >= r_asize) begin
                        n_full_hint         = '0;
                        n_res.ok            = 1'b1;
                        n_res.data_addr     = p_hu[AW-1:0];
                        if (bs_a > hu_a + r_asize) begin
                            // split: tail becomes a new free block
                            w_we         = 1'b1;
                            w_waddr      = AW'(p_hu + PW'(r_asize));
                            w_wdata      = '{free: 1'b1,
                                             size: SW'(bs_a - r_asize - hu_a)};
                            n_pred_valid = 1'b1;
                            n_pred_block = AW'(p_hu + PW'(r_asize));
                            n_w2_addr    = r_p[AW-1:0];
                            n_w2_data    = '{free: 1'b0, size: SW'(r_asize)};
                            n_res.granted_units = SW'(r_asize);
                            n_state      = ffpa_pkg::S_WR2;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_p[AW-1:0];
                            w_wdata = '{free: 1'b0, size: q.size};
                            if (r_pred_valid && PW'(r_pred_block) == r_p) begin
                                n_pred_valid = 1'b0;
                            end
                            n_res.granted_units = q.size;
                            n_state = ffpa_pkg::S_DONE;
                        end
                    end else if (w_nx + hu_p >= u_p) begin
                        n_state = ffpa_pkg::S_WFAIL;
                    end else begin
                        w_raddr = w_nx[AW-1:0];
                        n_nx    = w_nx;
                        n_bs    = q.size;
                        n_state = ffpa_pkg::S_WNX;
                    end
                end else begin
                    n_tries = 1'b0;
                    n_p     = w_nx;
                    n_state = ffpa_pkg::S_WALK;
                end
            end

            ffpa_pkg::S_WNX: begin
                if (q.free) begin
                    if (UW'(q.size) >= eff_u || merged_p >= u_p) begin
                        n_res.status = ffpa_pkg::STAT_BAD_HDR;
                        n_state      = ffpa_pkg::S_DONE;
                    end else begin
                        // merge and revisit the same block
                        w_we    = 1'b1;
                        w_waddr = r_p[AW-1:0];
                        w_wdata = '{free: 1'b1, size: SW'(merged_p)};
                        if (r_pred_valid && PW'(r_pred_block) == r_nx) begin
                            n_pred_valid = 1'b0;
                        end
                        n_full_hint = '0;
                        n_state     = ffpa_pkg::S_WALK;
                    end
                end else begin
                    n_tries = 1'b0;
                    n_p     = r_nx;
                    n_state = ffpa_pkg::S_WALK;
                end
            end

            ffpa_pkg::S_WFAIL: begin
                n_pred_valid = r_wpv;
                n_pred_block = r_pp;
                if (r_single) begin
                    // prediction missed: full walk from the start
                    n_p      = '0;
                    n_single = 1'b0;
                    n_tries  = 1'b1;
                    n_maxn   = SW'(1);
                    n_wpv    = 1'b0;
                    n_pp     = '0;
                    n_state  = ffpa_pkg::S_WALK;
                end else begin
                    n_full_hint  = UW'(r_maxn);
                    n_res.status = ffpa_pkg::STAT_NO_SPACE;
                    n_state      = ffpa_pkg::S_DONE;
                end
            end

            ffpa_pkg::S_FHDR: begin
                n_bs    = q.size;
                n_nx    = f_nx;
                n_state = ffpa_pkg::S_DONE;
                if (UW'(q.size) >= eff_u) begin
                    n_res.status = ffpa_pkg::STAT_BAD_HDR;
                end else if (r_op == ffpa_pkg::OP_FREE) begin
                    if (q.free) begin
                        n_res.status = ffpa_pkg::STAT_DBL_FREE;
                    end else if (f_nx + hu_p < u_p) begin
                        w_raddr = f_nx[AW-1:0];
                        n_state = ffpa_pkg::S_FNX;
                    end else begin
                        w_we                = 1'b1;
                        w_waddr             = r_h;
                        w_wdata             = '{free: 1'b1, size: q.size};
                        n_pred_valid        = 1'b1;
                        n_pred_block        = r_h;
                        n_full_hint         = '0;
                        n_res.ok            = 1'b1;
                        n_res.data_addr     = r_addr;
                        n_res.granted_units = q.size;
                    end
                end else begin
                    if (q.free) begin
                        n_res.status = ffpa_pkg::STAT_BAD_HDR;
                    end else if (r_asize <= bs_a) begin
                        n_res.ok            = 1'b1;
                        n_res.data_addr     = r_addr;
                        n_res.granted_units = q.size;
                    end else if (f_nx + hu_p < u_p) begin
                        w_raddr = f_nx[AW-1:0];
                        n_state = ffpa_pkg::S_RNX;
                    end else begin
                        n_res.status        = ffpa_pkg::STAT_NO_SPACE;
                        n_res.data_addr     = r_addr;
                        n_res.granted_units = q.size;
                    end
                end
            end

            ffpa_pkg::S_FNX: begin
                n_state = ffpa_pkg::S_DONE;
                if (UW'(q.size) >= eff_u || (q.free && merged_p >= u_p)) begin
                    n_res.status = ffpa_pkg::STAT_BAD_HDR;
                end else begin
                    w_we                = 1'b1;
                    w_waddr             = r_h;
                    w_wdata             = '{free: 1'b1,
                                            size: q.free ? SW'(merged_p) : r_bs};
                    n_pred_valid        = 1'b1;
                    n_pred_block        = r_h;
                    n_full_hint         = '0;
                    n_res.ok            = 1'b1;
                    n_res.data_addr     = r_addr;
                    n_res.granted_units = q.free ? SW'(merged_p) : r_bs;
                end
            end

            ffpa_pkg::S_RNX: begin
                n_state = ffpa_pkg::S_DONE;
                if (q.free && (UW'(q.size) >= eff_u || merged_p >= u_p)) begin
                    n_res.status = ffpa_pkg::STAT_BAD_HDR;
                end else if (q.free && ASW'(merged_p) >= r_asize) begin
                    n_full_hint     = '0;
                    n_res.ok        = 1'b1;
                    n_res.data_addr = r_addr;
                    if (ASW'(merged_p) > r_asize + hu_a) begin
                        w_we         = 1'b1;
                        w_waddr      = AW'(PW'(r_addr) + PW'(r_asize));
                        w_wdata      = '{free: 1'b1,
                                         size: SW'(ASW'(merged_p) - r_asize - hu_a)};
                        n_pred_valid = 1'b1;
                        n_pred_block = AW'(PW'(r_addr) + PW'(r_asize));
                        n_w2_addr    = r_h;
                        n_w2_data    = '{free: 1'b0, size: SW'(r_asize)};
                        n_res.granted_units = SW'(r_asize);
                        n_state      = ffpa_pkg::S_WR2;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_h;
                        w_wdata = '{free: 1'b0, size: SW'(merged_p)};
                        if (r_pred_valid && (r_pred_block == r_h ||
                                             PW'(r_pred_block) == r_nx)) begin
                            n_pred_valid = 1'b0;
                        end
                        n_res.granted_units = SW'(merged_p);
                    end
                end else begin
                    n_res.status        = ffpa_pkg::STAT_NO_SPACE;
                    n_res.data_addr     = r_addr;
                    n_res.granted_units = r_bs;
                end
            end

            ffpa_pkg::S_WR2: begin
                w_we    = 1'b1;
                w_waddr = r_w2_addr;
                w_wdata = r_w2_data;
                n_state = ffpa_pkg::S_DONE;
            end

            ffpa_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ffpa_pkg::S_IDLE;
                end
            end

            default: n_state = ffpa_pkg::S_INIT;
        endcase

        // any register write restores the pool
        if (i_cfg_we && i_cfg_index <= ffpa_pkg::CFG_POOL_UNITS) begin
            n_state = ffpa_pkg::S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ffpa_pkg::S_INIT;
            r_out_valid  <= 1'b0;
            r_pred_valid <= 1'b1;
            r_pred_block <= '0;
            r_full_hint  <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_pred_valid <= n_pred_valid;
            r_pred_block <= n_pred_block;
            r_full_hint  <= n_full_hint;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_asize   <= n_asize;
        r_addr    <= n_addr;
        r_h       <= n_h;
        r_p       <= n_p;
        r_nx      <= n_nx;
        r_bs      <= n_bs;
        r_maxn    <= n_maxn;
        r_wpv     <= n_wpv;
        r_pp      <= n_pp;
        r_tries   <= n_tries;
        r_single  <= n_single;
        r_w2_addr <= n_w2_addr;
        r_w2_data <= n_w2_data;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != ffpa_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    a_ok_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.ok == (r_out.status == ffpa_pkg::STAT_OK)))
        else $error("ok flag disagrees with status");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffpa_pkg::S_DONE && (!r_out_valid || !i_out_stall) && !i_cfg_we)
        |=> (r_out_valid && r_state == ffpa_pkg::S_IDLE))
        else $error("finished result not moved to output register");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffpa_pkg::S_IDLE && !i_in_valid) |-> !w_we)
        else $error("header write while idle");

    a_split_then_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffpa_pkg::S_WR2) |-> ($past(w_we) && w_we))
        else $error("split without header pair");

endmodule

/* hdl/ffpa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ram
// Simple dual-port RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffpa_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 13
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
